// File: src/lsrs_pkg.sv
// ---------------------------------------------------------------------------
// lsrs_pkg
// Shared constants, codes and helper functions for the lidar steering core.
// ---------------------------------------------------------------------------
package lsrs_pkg;

  localparam int unsigned DEF_MAX_SCAN_SAMPLES = 2048;
  localparam int unsigned DEF_CORDIC_STEPS     = 16;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_AVOID_THRESH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_SCAN = 3'd5;

  localparam logic [1:0] KIND_AVOID_TURN = 2'd0;
  localparam logic [1:0] KIND_AVOID_DONE = 2'd1;
  localparam logic [1:0] KIND_PILLAR     = 2'd2;

  localparam logic signed [15:0] PI_Q13      = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [16:0] CORDIC_GAIN = 17'sd39797;
  localparam logic signed [20:0] MIN_TRACK_X = 21'sd102;

  // atan(2^-k) scaled by 2^24
  function automatic logic signed [27:0] atan_lut(input logic [4:0] k);
    logic signed [27:0] v;
    case (k)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

  // shift right by 8, round half away from zero
  function automatic logic signed [39:0] rnd8(input logic signed [39:0] v);
    logic [39:0] mag;
    mag = v[39] ? 40'(-v) : 40'(v);
    mag = (mag + 40'd128) >> 8;
    return v[39] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) r = 16'sh7fff;
    else if (v < -40'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// File: src/lidar_scan_reactive_steering_core.sv
// ---------------------------------------------------------------------------
// lidar_scan_reactive_steering_core
// Per-half range minimum tracking and end-of-scan steering commands; the
// steering math shares one multiplier and an iterative cordic rotator.
// ---------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, range_sample          | sample words in
//  out     | out_valid, out_stall, linear_velocity,    | command words out
//          | angular_velocity, command_kind, last_of_scan
//  cfg     | cfg_we, cfg_index, cfg_data               | register writes
//
// a sample that does not end a scan is accepted without raising in_stall
// after the final sample of a scan, in_stall stays high through selection,
// shared multiplier passes and cordic iterations (steps capped at 24), then
// until every command word has been taken, which out_stall can hold off
// rst is synchronous and restores register defaults and tracking state
module lidar_scan_reactive_steering_core
  import lsrs_pkg::*;
#(
  parameter int unsigned MAX_SCAN_SAMPLES = DEF_MAX_SCAN_SAMPLES,
  parameter int unsigned CORDIC_STEPS     = DEF_CORDIC_STEPS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          range_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   linear_velocity,
  output logic signed [15:0]   angular_velocity,
  output logic [1:0]           command_kind,
  output logic                 last_of_scan
);

  localparam int unsigned LIMIT_I = (MAX_SCAN_SAMPLES < 2048) ? MAX_SCAN_SAMPLES : 2048;
  localparam logic [11:0] LIMIT   = 12'(LIMIT_I);
  localparam int unsigned STEPS_I = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam logic [4:0]  LAST_K  = 5'(STEPS_I - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SEL, S_M1, S_M2, S_M3, S_CINIT, S_CLOAD, S_CORD,
    S_CX, S_DEC, S_PX, S_PY, S_OUT
  } state_t;

  state_t state;

  logic [15:0] avoid_thresh, linear_gain, turn_gain;
  logic [15:0] start_angle;
  logic [14:0] angle_step;
  logic [11:0] samples_per_scan;

  logic [10:0] sample_count;
  logic [15:0] right_min_range, right_min_angle, left_min_range, left_min_angle;
  logic        avoiding_flag, arrived_flag;

  logic [15:0]        near_range;
  logic signed [15:0] ang_fold;
  logic               neg;
  logic               big_sel;
  logic signed [36:0] prod;
  logic signed [15:0] lin_r;
  logic signed [35:0] cx, cy;
  logic signed [27:0] cz;
  logic [4:0]         k;
  logic signed [19:0] xr, yr;

  logic signed [15:0] buf_lin [2];
  logic signed [15:0] buf_ang [2];
  logic [1:0]         buf_kind [2];
  logic [1:0]         cnt;
  logic               rd;

  // sample path
  logic [11:0] n_clamp;
  logic [10:0] half;
  logic [25:0] step_prod;
  logic [15:0] ang;
  logic        scan_end;

  always_comb begin
    if (samples_per_scan < 12'd2) n_clamp = 12'd2;
    else if (samples_per_scan > LIMIT) n_clamp = LIMIT;
    else n_clamp = samples_per_scan;
    half      = n_clamp[11:1];
    step_prod = {15'd0, sample_count} * {11'd0, angle_step};
    ang       = start_angle + step_prod[15:0];
    scan_end  = !(({1'b0, sample_count} + 12'd1) < n_clamp);
  end

  // end-of-scan selection
  logic [15:0]        sel_dist;
  logic signed [15:0] sel_ang;
  logic [17:0]        clear_lvl, triple_av;
  logic [15:0]        far_min;
  logic               av_hit;

  always_comb begin
    if (left_min_range < right_min_range) begin
      sel_dist = left_min_range;
      sel_ang  = $signed(left_min_angle);
    end else begin
      sel_dist = right_min_range;
      sel_ang  = $signed(right_min_angle);
    end
    clear_lvl = {1'b0, avoid_thresh, 1'b0} + 18'd256;
    triple_av = {2'b0, avoid_thresh} + {1'b0, avoid_thresh, 1'b0};
    far_min   = (left_min_range >= right_min_range) ? left_min_range : right_min_range;
    av_hit    = sel_dist < avoid_thresh;
  end

  // shared multiplier operands
  logic signed [19:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [36:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1: begin
        mul_a = $signed({4'd0, near_range}) - $signed({4'd0, avoid_thresh});
        mul_b = $signed({1'b0, linear_gain});
      end
      S_M2: begin
        mul_a = ({2'b0, far_min} > triple_av) ? $signed({4'd0, avoid_thresh})
                                               : $signed({4'd0, far_min});
        mul_b = $signed({1'b0, turn_gain});
      end
      S_CINIT: begin
        mul_a = $signed({4'd0, near_range});
        mul_b = CORDIC_GAIN;
      end
      S_DEC: begin
        mul_a = xr;
        mul_b = $signed({1'b0, linear_gain});
      end
      S_PX: begin
        mul_a = yr;
        mul_b = $signed({1'b0, turn_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 37'(mul_a * mul_b);
  end

  // turn magnitude scaling: *60 or *20 by shift and add
  logic signed [39:0] p40, turn_v;
  always_comb begin
    p40    = 40'(prod);
    turn_v = big_sel ? ((p40 <<< 6) - (p40 <<< 2)) : ((p40 <<< 4) + (p40 <<< 2));
    if (left_min_range < right_min_range) turn_v = -turn_v;
  end

  // cordic step and final rounding
  logic signed [35:0] cx_sh, cy_sh;
  logic [35:0]        xm, ym;
  logic signed [19:0] xr_c, yr_c;

  always_comb begin
    cx_sh = cx >>> k;
    cy_sh = cy >>> k;
    xm    = cx[35] ? 36'(-cx) : 36'(cx);
    ym    = cy[35] ? 36'(-cy) : 36'(cy);
    xm    = (xm + 36'd32768) >> 16;
    ym    = (ym + 36'd32768) >> 16;
    xr_c  = (cx[35] ^ neg) ? -$signed(xm[19:0]) : $signed(xm[19:0]);
    yr_c  = (cy[35] ^ neg) ? -$signed(ym[19:0]) : $signed(ym[19:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      avoid_thresh     <= 16'd256;
      linear_gain      <= 16'd128;
      turn_gain        <= 16'd64;
      start_angle      <= 16'h9b78;
      angle_step       <= 15'd143;
      samples_per_scan <= 12'd720;
      sample_count     <= '0;
      right_min_range  <= 16'hffff;
      right_min_angle  <= '0;
      left_min_range   <= 16'hffff;
      left_min_angle   <= '0;
      avoiding_flag    <= 1'b0;
      arrived_flag     <= 1'b0;
      cnt              <= '0;
      rd               <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AVOID_THRESH:     avoid_thresh     <= cfg_data;
          CFG_LINEAR_GAIN:      linear_gain      <= cfg_data;
          CFG_TURN_GAIN:        turn_gain        <= cfg_data;
          CFG_START_ANGLE:      start_angle      <= cfg_data;
          CFG_ANGLE_STEP:       angle_step       <= cfg_data[14:0];
          CFG_SAMPLES_PER_SCAN: samples_per_scan <= cfg_data[11:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (sample_count < half) begin
              if (sample_count == 11'd0 || range_sample < right_min_range) begin
                right_min_range <= range_sample;
                right_min_angle <= ang;
              end
            end else if (sample_count == half || range_sample < left_min_range) begin
              left_min_range <= range_sample;
              left_min_angle <= ang;
            end
            if (scan_end) begin
              sample_count <= '0;
              state        <= S_SEL;
            end else begin
              sample_count <= sample_count + 11'd1;
            end
          end
        end
        S_SEL: begin
          near_range <= sel_dist;
          if (sel_ang > HALF_PI_Q13) begin
            ang_fold <= sel_ang - PI_Q13;
            neg      <= 1'b1;
          end else if (sel_ang < -HALF_PI_Q13) begin
            ang_fold <= sel_ang + PI_Q13;
            neg      <= 1'b1;
          end else begin
            ang_fold <= sel_ang;
            neg      <= 1'b0;
          end
          if (avoiding_flag || av_hit) begin
            if ({2'b0, left_min_range} >= clear_lvl && {2'b0, right_min_range} >= clear_lvl) begin
              avoiding_flag <= 1'b0;
              buf_lin[cnt[0]]  <= sat16(40'($signed({1'b0, linear_gain})));
              buf_ang[cnt[0]]  <= '0;
              buf_kind[cnt[0]] <= KIND_AVOID_DONE;
              cnt   <= cnt + 2'd1;
              state <= S_CINIT;
            end else begin
              avoiding_flag <= 1'b1;
              state         <= S_M1;
            end
          end else begin
            state <= S_CINIT;
          end
        end
        S_M1: begin
          prod  <= mul_p;
          state <= S_M2;
        end
        S_M2: begin
          lin_r   <= sat16(rnd8(40'(prod)));
          prod    <= mul_p;
          big_sel <= {2'b0, far_min} > triple_av;
          state   <= S_M3;
        end
        S_M3: begin
          buf_lin[cnt[0]]  <= lin_r;
          buf_ang[cnt[0]]  <= sat16(rnd8(turn_v));
          buf_kind[cnt[0]] <= KIND_AVOID_TURN;
          cnt   <= cnt + 2'd1;
          state <= S_CINIT;
        end
        S_CINIT: begin
          prod  <= mul_p;
          state <= S_CLOAD;
        end
        S_CLOAD: begin
          cx    <= 36'(prod);
          cy    <= '0;
          cz    <= {{1{ang_fold[15]}}, ang_fold, 11'd0};
          k     <= '0;
          state <= S_CORD;
        end
        S_CORD: begin
          if (!cz[27]) begin
            cx <= cx - cy_sh;
            cy <= cy + cx_sh;
            cz <= cz - atan_lut(k);
          end else begin
            cx <= cx + cy_sh;
            cy <= cy - cx_sh;
            cz <= cz + atan_lut(k);
          end
          k <= k + 5'd1;
          if (k == LAST_K) state <= S_CX;
        end
        S_CX: begin
          xr    <= xr_c;
          yr    <= yr_c;
          state <= S_DEC;
        end
        S_DEC: begin
          if ($signed({xr[19], xr}) > $signed({5'd0, avoid_thresh}) && !arrived_flag) begin
            if ($signed({xr[19], xr}) > MIN_TRACK_X) begin
              prod  <= mul_p;
              state <= S_PX;
            end else begin
              buf_lin[cnt[0]]  <= '0;
              buf_ang[cnt[0]]  <= '0;
              buf_kind[cnt[0]] <= KIND_PILLAR;
              cnt   <= cnt + 2'd1;
              state <= S_OUT;
            end
          end else begin
            arrived_flag <= 1'b1;
            state        <= S_OUT;
          end
        end
        S_PX: begin
          lin_r <= sat16(rnd8(40'(prod)));
          prod  <= mul_p;
          state <= S_PY;
        end
        S_PY: begin
          buf_lin[cnt[0]]  <= lin_r;
          buf_ang[cnt[0]]  <= sat16(rnd8(40'(prod)));
          buf_kind[cnt[0]] <= KIND_PILLAR;
          cnt   <= cnt + 2'd1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (cnt == 2'd0) begin
            state <= S_IDLE;
          end else if (!out_stall) begin
            if ({1'b0, rd} == cnt - 2'd1) begin
              cnt   <= '0;
              rd    <= 1'b0;
              state <= S_IDLE;
            end else begin
              rd <= rd + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state != S_IDLE);
  assign out_valid        = (state == S_OUT) && (cnt != 2'd0);
  assign linear_velocity  = buf_lin[rd];
  assign angular_velocity = buf_ang[rd];
  assign command_kind     = buf_kind[rd];
  assign last_of_scan     = ({1'b0, rd} == cnt - 2'd1);

endmodule

// File: src/lsrs_checker.sv
// ---------------------------------------------------------------------------
// lsrs_checker
// Port-level checks for the lidar steering core, bound to the top level.
// ---------------------------------------------------------------------------
module lsrs_checker
  import lsrs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [15:0] linear_velocity,
  input logic [1:0]        command_kind,
  input logic              last_of_scan
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(linear_velocity))
    else $error("stalled word changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while commands pending");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (command_kind == KIND_AVOID_TURN || command_kind == KIND_AVOID_DONE ||
                   command_kind == KIND_PILLAR))
    else $error("bad command kind");

  a_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_scan |=> out_valid)
    else $error("second command missing");

  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_of_scan |=> !out_valid)
    else $error("command after last of scan");

endmodule

bind lidar_scan_reactive_steering_core lsrs_checker u_lsrs_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .linear_velocity(linear_velocity),
  .command_kind(command_kind), .last_of_scan(last_of_scan)
);

// File: tb/sv/tb_lidar_scan_reactive_steering_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_lidar_scan_reactive_steering_core
// Self-checking bench for the lidar steering core. Range words are streamed
// scan by scan under several register settings; a behavioral model of the
// minimum tracking, avoidance logic and cordic rotation predicts every
// command word, which is compared field by field as the core hands it over.
// ---------------------------------------------------------------------------
module tb_lidar_scan_reactive_steering_core;
  import lsrs_pkg::*;

  localparam int CLK_HI = 6;
  localparam int CLK_LO = 6;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int TARGET_WORDS = 1700;

  typedef struct packed {
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic [1:0]         kind;
    logic               last;
  } steer_cmd_t;

  // atan(2^-k) scaled by 2^24
  localparam longint ATAN_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_AVOID_THRESH;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [15:0]          range_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [15:0]   linear_velocity;
  logic signed [15:0]   angular_velocity;
  logic [1:0]           command_kind;
  logic                 last_of_scan;

  lidar_scan_reactive_steering_core uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .range_sample(range_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .linear_velocity(linear_velocity), .angular_velocity(angular_velocity),
    .command_kind(command_kind), .last_of_scan(last_of_scan)
  );

  always begin
    #CLK_HI clk = 1'b1;
    #CLK_LO clk = 1'b0;
  end

  // model registers and tracking state
  logic [15:0] m_avoid = 16'd256, m_lin_gain = 16'd128, m_turn_gain = 16'd64;
  logic [15:0] m_start = 16'h9B78;
  logic [14:0] m_step = 15'd143;
  logic [11:0] m_spp = 12'd720;
  logic [10:0] m_count = '0;
  logic [15:0] m_rmin = 16'hFFFF, m_rang = '0, m_lmin = 16'hFFFF, m_lang = '0;
  logic        m_avoiding = 1'b0, m_arrived = 1'b0;

  steer_cmd_t cmd_q[$];
  int errors = 0, words_sent = 0, scans_sent = 0, cycles = 0;
  int kind_seen[3] = '{0, 0, 0};
  bit idle_en = 1'b1;
  int hold_req = 0;

  function automatic longint round_shift(input longint v, input int s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic polar_xy(input longint d, input int a_in, output longint xo, output longint yo);
    bit neg;
    longint x, y, z, nx;
    int a;
    neg = 1'b0;
    a = a_in;
    if (a > 12868) begin
      a -= 25736; neg = 1'b1;
    end else if (a < -12868) begin
      a += 25736; neg = 1'b1;
    end
    x = d * 39797;
    y = 0;
    z = longint'(a) * 2048;
    for (int k = 0; k < DEF_CORDIC_STEPS && k < 24; k++) begin
      if (z >= 0) begin
        nx = x - (y >>> k); y = y + (x >>> k); z -= ATAN_Q24[k];
      end else begin
        nx = x + (y >>> k); y = y - (x >>> k); z += ATAN_Q24[k];
      end
      x = nx;
    end
    xo = round_shift(x, 16);
    yo = round_shift(y, 16);
    if (neg) begin
      xo = -xo; yo = -yo;
    end
  endtask

  task automatic push_cmd(input longint lin, input longint ang, input logic [1:0] kind);
    steer_cmd_t c;
    c.lin = clip16(lin); c.ang = clip16(ang); c.kind = kind; c.last = 1'b0;
    cmd_q.push_back(c);
  endtask

  // advances the model by one range word and queues the commands it yields
  task automatic predict_steering(input logic [15:0] r);
    int unsigned n, half, i, near_d, av, clr, sel;
    logic [15:0] ang, dang;
    longint mag, x, y, lin, rot;
    int produced;
    produced = 0;
    n = m_spp;
    if (n < 2) n = 2;
    if (n > 2048) n = 2048;
    half = n / 2;
    i = m_count;
    ang = 16'(m_start + i * m_step);
    if (i < half) begin
      if (i == 0 || r < m_rmin) begin
        m_rmin = r; m_rang = ang;
      end
    end else if (i == half || r < m_lmin) begin
      m_lmin = r; m_lang = ang;
    end
    if (i + 1 < n) begin
      m_count = 11'(i + 1);
      return;
    end
    m_count = '0;
    scans_sent++;
    if (m_lmin < m_rmin) begin
      near_d = m_lmin; dang = m_lang;
    end else begin
      near_d = m_rmin; dang = m_rang;
    end
    av = m_avoid;
    if (near_d < av) m_avoiding = 1'b1;
    if (m_avoiding) begin
      clr = 2 * av + 256;
      if (m_lmin >= clr && m_rmin >= clr) begin
        m_avoiding = 1'b0;
        push_cmd(m_lin_gain, 0, KIND_AVOID_DONE);
      end else begin
        lin = round_shift((longint'(near_d) - longint'(av)) * m_lin_gain, 8);
        sel = (m_lmin >= m_rmin) ? m_lmin : m_rmin;
        if (sel > 3 * av) mag = 60 * longint'(av) * m_turn_gain;
        else mag = longint'(sel) * m_turn_gain * 20;
        mag = round_shift(mag, 8);
        if (m_lmin < m_rmin) mag = -mag;
        push_cmd(lin, mag, KIND_AVOID_TURN);
      end
      produced++;
    end
    polar_xy(near_d, int'($signed(dang)), x, y);
    if (x > longint'(av) && !m_arrived) begin
      lin = 0; rot = 0;
      if (x > 102) begin
        lin = round_shift(x * m_lin_gain, 8);
        rot = round_shift(y * m_turn_gain, 8);
      end
      push_cmd(lin, rot, KIND_PILLAR);
      produced++;
    end else begin
      m_arrived = 1'b1;
    end
    if (produced > 0) cmd_q[cmd_q.size() - 1].last = 1'b1;
  endtask

  // range words are held off while a register is written
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    in_valid <= 1'b0;
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_AVOID_THRESH:     m_avoid = v;
      CFG_LINEAR_GAIN:      m_lin_gain = v;
      CFG_TURN_GAIN:        m_turn_gain = v;
      CFG_START_ANGLE:      m_start = v;
      CFG_ANGLE_STEP:       m_step = v[14:0];
      CFG_SAMPLES_PER_SCAN: m_spp = v[11:0];
      default: ;
    endcase
  endtask

  task automatic set_scan(input logic [15:0] av, input logic [15:0] start,
                          input logic [15:0] step, input logic [15:0] spp);
    write_reg(CFG_AVOID_THRESH, av);
    write_reg(CFG_START_ANGLE, start);
    write_reg(CFG_ANGLE_STEP, step);
    write_reg(CFG_SAMPLES_PER_SCAN, spp);
  endtask

  // one range word; optionally drops valid for a burst after acceptance
  task automatic send_range(input logic [15:0] r);
    int gap;
    in_valid <= 1'b1;
    range_sample <= r;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_steering(r);
    words_sent++;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block is idle once every command is out and the scan math has finished
  task automatic settle();
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_range(input logic [15:0] av);
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(av + $urandom_range(0, 8) - 4);
      3: return 16'(2 * av + 256 + $urandom_range(0, 8) - 4);
      4: return 16'(3 * av + $urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_scan(input logic [15:0] lo, input logic [15:0] hi);
    int n;
    n = (m_spp < 2) ? 2 : (m_spp > 2048 ? 2048 : int'(m_spp));
    repeat (n - m_count) send_range(16'($urandom_range(lo, hi)));
  endtask

  // pillar commands only appear until the arrival latch sets, so go first
  task automatic test_pillar_tracking();
    set_scan(16'd64, -16'sd4000, 16'd1000, 16'd8);
    write_reg(CFG_LINEAR_GAIN, 16'd300);
    write_reg(CFG_TURN_GAIN, 16'd200);
    repeat (8) send_range(16'hFFFF);
    send_scan(16'd300, 16'hFFFF);
    // tie between halves picks the right minimum
    repeat (8) send_range(16'd1000);
    settle();
    // track point too close to move toward: zero speeds
    write_reg(CFG_AVOID_THRESH, 16'd0);
    repeat (8) send_range(16'd90);
    settle();
    write_reg(CFG_AVOID_THRESH, 16'd64);
    repeat (10) send_scan(16'd400, 16'hFFFF);
    settle();
  endtask

  task automatic test_arrival();
    // nearest point behind the sensor, folded angle gives negative x
    set_scan(16'd64, 16'sd20000, 16'd100, 16'd4);
    repeat (4) send_range(16'd500);
    settle();
  endtask

  task automatic test_avoidance();
    set_scan(16'd256, 16'hA378, 16'd143, 16'd6);
    repeat (6) send_range(16'd100);
    repeat (3) send_range(16'd200);
    repeat (3) send_range(16'd900);
    repeat (3) send_range(16'd2000);
    repeat (3) send_range(16'd600);
    repeat (6) send_range(16'd768);
    for (int s = 0; s < 15; s++)
      for (int k = 0; k < 6; k++) send_range(pick_range(m_avoid));
    settle();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_LINEAR_GAIN, 16'hFFFF);
    write_reg(CFG_TURN_GAIN, 16'hFFFF);
    set_scan(16'hFFFF, 16'sh8000, 16'h7FFF, 16'd0);
    repeat (8) send_range(pick_range(m_avoid));
    settle();
    write_reg(CFG_LINEAR_GAIN, 16'd0);
    write_reg(CFG_TURN_GAIN, 16'd0);
    set_scan(16'd0, 16'sh7FFF, 16'd0, 16'd1);
    repeat (8) send_range(pick_range(m_avoid));
    settle();
    write_reg(CFG_LINEAR_GAIN, 16'd256);
    write_reg(CFG_TURN_GAIN, 16'd256);
    // oversized scan length clamps, so the halves split at word 1024
    set_scan(16'd300, 16'd0, 16'd7, 16'hFFF);
    repeat (1100) send_range(16'($urandom));
    settle();
    // shrinking the scan under a partial count ends it on the next word
    write_reg(CFG_SAMPLES_PER_SCAN, 16'd10);
    send_range(16'd50);
    settle();
  endtask

  task automatic test_backpressure();
    set_scan(16'd200, 16'd0, 16'd50, 16'd2);
    hold_req++;
    repeat (16) send_range(pick_range(m_avoid));
    settle();
  endtask

  task automatic test_random_scans();
    while (words_sent < TARGET_WORDS) begin
      if (words_sent > TARGET_WORDS - 150) idle_en = 1'b0;
      write_reg(CFG_LINEAR_GAIN, 16'($urandom));
      write_reg(CFG_TURN_GAIN, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 512)));
      set_scan(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500)),
               16'($urandom), 16'($urandom),
               ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 80))
                                          : 16'($urandom_range(2, 10)));
      repeat ($urandom_range(2, 8))
        repeat ((m_spp < 2) ? 2 : int'(m_spp)) send_range(pick_range(m_avoid));
      settle();
    end
  endtask

  // receiver: random stall bursts plus one long hold-off on request
  int hold_seen = 0, stall_left = 0;
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      stall_left <= 300;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    steer_cmd_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{linear_velocity, angular_velocity, command_kind, last_of_scan};
      if (cmd_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected command word: lin %0d ang %0d kind %0d last %0b",
                   got.lin, got.ang, got.kind, got.last);
      end else begin
        want = cmd_q.pop_front();
        if (want.kind <= KIND_PILLAR) kind_seen[want.kind]++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: lin %0d/%0d ang %0d/%0d kind %0d/%0d last %0b/%0b",
                     want.lin, got.lin, want.ang, got.ang, want.kind, got.kind,
                     want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_lidar_scan_reactive_steering_core: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pillar_tracking();
    test_arrival();
    test_avoidance();
    test_register_extremes();
    test_backpressure();
    test_random_scans();
    settle();
    $display("%0d range words over %0d scans; commands turn %0d, clear %0d, pillar %0d",
             words_sent, scans_sent, kind_seen[0], kind_seen[1], kind_seen[2]);
    if (errors == 0 && cmd_q.size() == 0)
      $display("tb_lidar_scan_reactive_steering_core: clean");
    else
      $display("tb_lidar_scan_reactive_steering_core: errors");
    $finish;
  end

endmodule

// File: lidar_scan_reactive_steering_core.f
src/lsrs_pkg.sv
src/lidar_scan_reactive_steering_core.sv
src/lsrs_checker.sv
tb/sv/tb_lidar_scan_reactive_steering_core.sv
